// File: src/sfpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame pattern checker package
// Shared widths, codes and the record that passes from classifier to counters.
// ----------------------------------------------------------------------------
package sfpc_pkg;

  // Frame format
  localparam int unsigned MAX_PAYLOAD_BYTES = 65536;
  localparam int unsigned LEN_W             = 17;
  localparam int unsigned IDX_W             = 31;
  localparam int unsigned BYTES_W           = 40;
  localparam int unsigned HEADER_END        = 5;
  localparam int unsigned FRAME_EXTRA       = 6;
  localparam logic [7:0]  START_BYTE        = 8'h02;
  localparam logic [7:0]  END_BYTE          = 8'h03;

  // Configuration register map (word index)
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd0;
  localparam logic [1:0] REG_FRAME_COUNT    = 2'd1;
  localparam logic [1:0] REG_PATTERN_MODE   = 2'd2;
  localparam logic [LEN_W-1:0] PAYLOAD_LENGTH_RESET = LEN_W'(1024);

  // Error codes, lowest code wins
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SIZE      = 3'd1,
    ERR_START_END = 3'd2,
    ERR_NUMBER    = 3'd3,
    ERR_PAYLOAD   = 3'd4
  } sfpc_err_e;

  // One closed frame as seen by the counter stage
  typedef struct packed {
    sfpc_err_e              kind;
    logic [IDX_W-1:0]       frame_index;
    logic [LEN_W-1:0]       frame_len;
    logic                   done;
  } sfpc_close_t;

endpackage

// File: src/sfpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame pattern checker channels
// Valid/ready channels for received bytes and for per-frame results.
// ----------------------------------------------------------------------------
interface sfpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       timeout;

  modport source (output valid, output rx_byte, output timeout, input ready);
  modport sink   (input valid, input rx_byte, input timeout, output ready);
endinterface

interface sfpc_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [2:0]  error_kind;
  logic [30:0] frame_index;
  logic [30:0] good_frames;
  logic [30:0] error_frames;
  logic [39:0] good_bytes;
  logic        all_done;

  modport source (output valid, output frame_ok, output error_kind, output frame_index,
                  output good_frames, output error_frames, output good_bytes,
                  output all_done, input ready);
  modport sink   (input valid, input frame_ok, input error_kind, input frame_index,
                  input good_frames, input error_frames, input good_bytes,
                  input all_done, output ready);
endinterface

// File: src/sfpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame pattern checker front end
// Takes one byte per cycle while the close queue has room, tracks the frame position and closes frames.
// ----------------------------------------------------------------------------
module sfpc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  sfpc_in_if.sink                   rx_i,
  input  logic [sfpc_pkg::LEN_W-1:0] payload_length_i,
  input  logic [sfpc_pkg::IDX_W-1:0] frame_count_i,
  input  logic                      pattern_mode_i,
  input  logic                      queue_full_i,
  output logic                      close_valid_o,
  output sfpc_pkg::sfpc_close_t     close_o,
  output logic                      finished_o
);

  logic [sfpc_pkg::LEN_W-1:0] pos_q, pos_d;
  logic [31:0]                num_q, num_d;
  logic                       se_bad_q, se_bad_d;
  logic                       pl_bad_q, pl_bad_d;
  logic [sfpc_pkg::IDX_W-1:0] exp_idx_q, exp_idx_d;
  logic                       finished_q, finished_d;

  logic                       take;
  logic [sfpc_pkg::LEN_W-1:0] eff_len;
  logic [sfpc_pkg::LEN_W-1:0] end_pos;
  logic [7:0]                 pat_j;
  logic [7:0]                 pat_want;
  logic                       at_end;
  logic                       se_bad_fin;
  logic [sfpc_pkg::IDX_W-1:0] nxt_idx;
  sfpc_pkg::sfpc_err_e        kind;

  // Items are dropped on the floor once the run is finished
  assign rx_i.ready = !queue_full_i;
  assign take       = rx_i.valid && rx_i.ready && !finished_q;

  // Clamp the length and locate the end byte
  assign eff_len = (payload_length_i > sfpc_pkg::LEN_W'(sfpc_pkg::MAX_PAYLOAD_BYTES)) ?
                   sfpc_pkg::LEN_W'(sfpc_pkg::MAX_PAYLOAD_BYTES) : payload_length_i;
  assign end_pos = eff_len + sfpc_pkg::LEN_W'(sfpc_pkg::HEADER_END);
  assign at_end  = (pos_q >= end_pos);

  // Expected payload byte; descending is the bitwise inverse
  assign pat_j    = 8'(pos_q - sfpc_pkg::LEN_W'(sfpc_pkg::HEADER_END));
  assign pat_want = pattern_mode_i ? ~pat_j : pat_j;

  assign se_bad_fin = se_bad_q || (rx_i.rx_byte != sfpc_pkg::END_BYTE);
  assign nxt_idx    = exp_idx_q + sfpc_pkg::IDX_W'(1);

  // Error priority at frame close
  always_comb begin
    priority if (rx_i.timeout) begin
      kind = sfpc_pkg::ERR_SIZE;
    end else if (se_bad_fin) begin
      kind = sfpc_pkg::ERR_START_END;
    end else if (num_q != {1'b0, exp_idx_q}) begin
      kind = sfpc_pkg::ERR_NUMBER;
    end else if (pl_bad_q) begin
      kind = sfpc_pkg::ERR_PAYLOAD;
    end else begin
      kind = sfpc_pkg::ERR_NONE;
    end
  end

  // Frame state update
  always_comb begin
    pos_d         = pos_q;
    num_d         = num_q;
    se_bad_d      = se_bad_q;
    pl_bad_d      = pl_bad_q;
    exp_idx_d     = exp_idx_q;
    finished_d    = finished_q;
    close_valid_o = 1'b0;
    if (take) begin
      if (rx_i.timeout || at_end) begin
        close_valid_o = 1'b1;
        pos_d         = '0;
        num_d         = '0;
        se_bad_d      = 1'b0;
        pl_bad_d      = 1'b0;
        exp_idx_d     = nxt_idx;
        finished_d    = (nxt_idx >= frame_count_i) || (nxt_idx == '0);
      end else begin
        pos_d = pos_q + sfpc_pkg::LEN_W'(1);
        if (pos_q == '0) begin
          se_bad_d = se_bad_q || (rx_i.rx_byte != sfpc_pkg::START_BYTE);
        end else if (pos_q < sfpc_pkg::LEN_W'(sfpc_pkg::HEADER_END)) begin
          num_d = {rx_i.rx_byte, num_q[31:8]};
        end else begin
          pl_bad_d = pl_bad_q || (rx_i.rx_byte != pat_want);
        end
      end
    end
  end

  assign close_o.kind        = kind;
  assign close_o.frame_index = exp_idx_q;
  assign close_o.frame_len   = eff_len;
  assign close_o.done        = finished_d;
  assign finished_o          = finished_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      num_q      <= '0;
      se_bad_q   <= 1'b0;
      pl_bad_q   <= 1'b0;
      exp_idx_q  <= '0;
      finished_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      num_q      <= num_d;
      se_bad_q   <= se_bad_d;
      pl_bad_q   <= pl_bad_d;
      exp_idx_q  <= exp_idx_d;
      finished_q <= finished_d;
    end
  end

endmodule

// File: src/sfpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame pattern checker close queue
// Two-entry FIFO of closed-frame records between front end and counters.
// ----------------------------------------------------------------------------
module sfpc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sfpc_pkg::sfpc_close_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output sfpc_pkg::sfpc_close_t head_o
);

  sfpc_pkg::sfpc_close_t mem_q [2];
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: src/sfpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame pattern checker back end
// Updates the pass/fail/byte counters and holds the result register.
// ----------------------------------------------------------------------------
module sfpc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  sfpc_pkg::sfpc_close_t head_i,
  output logic                  pop_o,
  sfpc_out_if.source            res_o
);

  localparam logic [sfpc_pkg::IDX_W-1:0]   CntMax   = '1;
  localparam logic [sfpc_pkg::BYTES_W-1:0] BytesMax = '1;

  logic [sfpc_pkg::IDX_W-1:0]   pass_q, pass_d;
  logic [sfpc_pkg::IDX_W-1:0]   fail_q, fail_d;
  logic [sfpc_pkg::BYTES_W-1:0] total_q, total_d;
  logic                         out_valid_q;
  logic                         ok_q;
  sfpc_pkg::sfpc_err_e          kind_q;
  logic [sfpc_pkg::IDX_W-1:0]   idx_q;
  logic                         done_q;

  logic                         is_ok;
  logic [sfpc_pkg::BYTES_W:0]   sum;

  // Take the next record when the result slot is free or being emptied
  assign pop_o = head_valid_i && (!out_valid_q || res_o.ready);
  assign is_ok = (head_i.kind == sfpc_pkg::ERR_NONE);
  assign sum   = {1'b0, total_q} + (sfpc_pkg::BYTES_W + 1)'(head_i.frame_len)
               + (sfpc_pkg::BYTES_W + 1)'(sfpc_pkg::FRAME_EXTRA);

  // Saturating counters
  always_comb begin
    pass_d  = pass_q;
    fail_d  = fail_q;
    total_d = total_q;
    if (pop_o) begin
      if (is_ok) begin
        if (pass_q != CntMax) begin
          pass_d = pass_q + sfpc_pkg::IDX_W'(1);
        end
        total_d = sum[sfpc_pkg::BYTES_W] ? BytesMax : sum[sfpc_pkg::BYTES_W-1:0];
      end else if (fail_q != CntMax) begin
        fail_d = fail_q + sfpc_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q      <= '0;
      fail_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pass_q  <= pass_d;
      fail_q  <= fail_d;
      total_q <= total_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ok_q   <= is_ok;
      kind_q <= head_i.kind;
      idx_q  <= head_i.frame_index;
      done_q <= head_i.done;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.frame_ok     = ok_q;
  assign res_o.error_kind   = kind_q;
  assign res_o.frame_index  = idx_q;
  assign res_o.good_frames  = pass_q;
  assign res_o.error_frames = fail_q;
  assign res_o.good_bytes   = total_q;
  assign res_o.all_done     = done_q;

endmodule

// File: src/serial_frame_pattern_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame pattern checker
// Checks test frames (start, 4-byte number, patterned payload, end) on a byte
// stream and reports one result per closed frame with running counters.
// ----------------------------------------------------------------------------
// Takes one byte item per cycle while rx_i.ready is high. A frame closes on
// its end byte or on a timeout item. The closing item's record enters a
// two-entry queue at the edge that accepts that item. The counter stage then
// loads it into the result register once the result slot is free or being
// emptied. rx_i.ready drops only when the queue is full, which happens only
// after the result channel has held off for a while. After frame_count
// frames every further item is taken and ignored until reset. Registers sit
// at byte addresses 0 (payload_length), 4 (frame_count) and 8 (pattern_mode);
// no clearing pass follows reset.
module serial_frame_pattern_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sfpc_in_if.sink                     rx_i,
  sfpc_out_if.source                  res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [sfpc_pkg::LEN_W-1:0] payload_length_q;
  logic [sfpc_pkg::IDX_W-1:0] frame_count_q;
  logic                       pattern_mode_q;
  logic [1:0]                 reg_idx;
  logic                       wr_en;

  logic                       q_full;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_valid;
  sfpc_pkg::sfpc_close_t      q_in;
  sfpc_pkg::sfpc_close_t      q_head;
  logic                       finished;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_length_q <= sfpc_pkg::PAYLOAD_LENGTH_RESET;
      frame_count_q    <= sfpc_pkg::IDX_W'(1);
      pattern_mode_q   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        sfpc_pkg::REG_PAYLOAD_LENGTH: payload_length_q <= pwdata[sfpc_pkg::LEN_W-1:0];
        sfpc_pkg::REG_FRAME_COUNT:    frame_count_q    <= pwdata[sfpc_pkg::IDX_W-1:0];
        sfpc_pkg::REG_PATTERN_MODE:   pattern_mode_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sfpc_pkg::REG_PAYLOAD_LENGTH: prdata = 32'(payload_length_q);
      sfpc_pkg::REG_FRAME_COUNT:    prdata = 32'(frame_count_q);
      sfpc_pkg::REG_PATTERN_MODE:   prdata = 32'(pattern_mode_q);
      default:                      prdata = '0;
    endcase
  end

  // Byte classifier
  sfpc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_i             (rx_i),
    .payload_length_i (payload_length_q),
    .frame_count_i    (frame_count_q),
    .pattern_mode_i   (pattern_mode_q),
    .queue_full_i     (q_full),
    .close_valid_o    (q_push),
    .close_o          (q_in),
    .finished_o       (finished)
  );

  // Closed-frame queue
  sfpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // Counters and result register
  sfpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .res_o        (res_o)
  );

`ifndef SYNTHESIS
  // A closing item is only taken when the queue has room
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("close record pushed into full queue");

  // Nothing closes once the run has finished
  a_quiet_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished |-> !q_push)
    else $error("frame closed after run finished");

  // Pass flag agrees with the error code
  a_ok_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.frame_ok == (res_o.error_kind == sfpc_pkg::ERR_NONE)))
    else $error("frame_ok disagrees with error_kind");

  // A popped record always reaches the result register
  a_pop_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> res_o.valid)
    else $error("popped record did not reach result register");
`endif

endmodule
